/* design/pfx_pkg.sv */
// Package with the types, constants and codes of the postfix evaluator.
package pfx_pkg;

    localparam int StackDepth = 64;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);

    localparam logic [7:0] SymZero  = 8'h30;
    localparam logic [7:0] SymNine  = 8'h39;
    localparam logic [7:0] SymPlus  = 8'h2B;
    localparam logic [7:0] SymMinus = 8'h2D;
    localparam logic [7:0] SymMul   = 8'h2A;
    localparam logic [7:0] SymDiv   = 8'h2F;
    localparam logic [7:0] SymPow   = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_BADSYM = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_R,
        S_RD_L,
        S_EXEC,
        S_DIV,
        S_POW,
        S_WB,
        S_TOP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_word_t;

endpackage

/* design/pfx_ram.sv */
// Generic single-port RAM with a registered read.
module pfx_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: control, stack RAM and arithmetic.
//
// The s_ channel takes one word per symbol: an ASCII digit pushes its value, and
// + - * / ^ pop the right and then the left operand and push the 32-bit wrapping
// result. The word with last set ends the expression; the block then sends one
// word on the m_ channel with the top of stack and a status code, and clears the
// stack and the error. Errors are sticky: after the first, symbols are ignored.
//
// The stack lives in a single-port RAM with a registered read. A digit or an
// ignored symbol passes through decode and the top-of-stack state. An add,
// subtract or multiply reads both operands from the RAM one after the other,
// then writes the result back. Divide adds a load step and a restoring divider
// at one quotient bit per cycle. Power runs square-and-multiply, alternating a
// multiply and a squaring step until no exponent bits are left. A last word
// adds a step to load the output register, plus any wait for it.
//
// Reset clears the stack count, the error and the state machine; stack
// contents are never cleared since only written entries are read. While the
// receiver stalls, the result waits in the output register and the block
// accepts the next symbols, but stops before loading another result.
module postfix_expression_evaluator
    import pfx_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    state_t state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    status_t err_reg, err_next;
    logic [7:0] sym_reg, sym_next;
    logic last_reg, last_next;
    logic [31:0] r_reg, r_next, l_reg, l_next, res_reg, res_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0] step_reg, step_next;
    logic sq_reg, sq_next;
    logic m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic ram_we;
    logic [PtrW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    pfx_ram #(.Width(32), .Depth(StackDepth)) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Divider working values (magnitudes, shifted and trial remainder), decode flags, multiplier.
    logic [31:0] l_mag, r_mag;
    logic [32:0] rem_shift;
    logic [32:0] rem_try;
    logic is_digit, is_op;
    logic [31:0] mul_a, mul_b, mul_p;

    assign l_mag = l_reg[31] ? (~l_reg + 32'd1) : l_reg;
    assign r_mag = r_reg[31] ? (~r_reg + 32'd1) : r_reg;
    // acc_reg holds the shifting dividend, res_reg the remainder during divide.
    assign rem_shift = {res_reg, acc_reg[31]};
    assign rem_try = rem_shift - {1'b0, r_mag};
    assign is_digit = (sym_reg >= SymZero) && (sym_reg <= SymNine);
    assign is_op = (sym_reg == SymPlus) || (sym_reg == SymMinus) || (sym_reg == SymMul)
        || (sym_reg == SymDiv) || (sym_reg == SymPow);

    // One shared 32x32 multiplier for multiply and power.
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        r_reg      <= r_next;
        l_reg      <= l_next;
        res_reg    <= res_next;
        acc_reg    <= acc_next;
        step_reg   <= step_next;
        sq_reg     <= sq_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        r_next       = r_reg;
        l_next       = l_reg;
        res_next     = res_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        sq_next      = sq_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_addr     = cnt_reg[PtrW-1:0] - PtrW'(1);
        ram_wdata    = res_reg;
        mul_a        = acc_reg;
        mul_b        = l_reg;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sym_next   = s_data.symbol;
                    last_next  = s_data.last;
                    state_next = S_EXEC;
                    step_next  = '0;
                end
            end
            S_EXEC: begin
                // Decode the symbol; digits push at once, operators read operands.
                if (err_reg != ST_OK) begin
                    state_next = S_TOP;
                end else if (is_digit) begin
                    if (cnt_reg >= CntW'(StackDepth)) begin
                        err_next = ST_OVER;
                    end else begin
                        ram_we    = 1'b1;
                        ram_addr  = cnt_reg[PtrW-1:0];
                        ram_wdata = {24'd0, sym_reg - SymZero};
                        cnt_next  = cnt_reg + CntW'(1);
                    end
                    state_next = S_TOP;
                end else if (!is_op) begin
                    err_next   = ST_BADSYM;
                    state_next = S_TOP;
                end else if (cnt_reg < CntW'(2)) begin
                    err_next   = ST_UNDER;
                    state_next = S_TOP;
                end else begin
                    ram_addr   = cnt_reg[PtrW-1:0] - PtrW'(1);
                    state_next = S_RD_R;
                end
            end
            S_RD_R: begin
                r_next     = ram_rdata;
                ram_addr   = cnt_reg[PtrW-1:0] - PtrW'(2);
                state_next = S_RD_L;
            end
            S_RD_L: begin
                l_next = ram_rdata;
                mul_a  = ram_rdata;
                mul_b  = r_reg;
                state_next = S_WB;
                case (sym_reg)
                    SymPlus:  res_next = ram_rdata + r_reg;
                    SymMinus: res_next = ram_rdata - r_reg;
                    SymMul:   res_next = mul_p;
                    SymDiv: begin
                        if (r_reg == 32'd0) begin
                            err_next   = ST_DIVZ;
                            state_next = S_TOP;
                        end else begin
                            state_next = S_DIV;
                            res_next   = '0;
                            step_next  = '0;
                        end
                    end
                    default: begin
                        // Power: negative exponent handled directly.
                        if (r_reg[31]) begin
                            if (ram_rdata == 32'd1) begin
                                res_next = 32'd1;
                            end else if (ram_rdata == 32'hFFFF_FFFF) begin
                                res_next = r_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                            end else begin
                                res_next = '0;
                            end
                        end else begin
                            res_next   = 32'd1;
                            acc_next   = ram_rdata;
                            sq_next    = 1'b0;
                            state_next = S_POW;
                        end
                    end
                endcase
            end
            S_DIV: begin
                // The first step loads the dividend magnitude; then one quotient bit per cycle.
                if (step_reg == 6'd0) begin
                    acc_next  = l_mag;
                    res_next  = '0;
                    step_next = 6'd1;
                end else begin
                    if (!rem_try[32]) begin
                        res_next = rem_try[31:0];
                        acc_next = {acc_reg[30:0], 1'b1};
                    end else begin
                        res_next = rem_shift[31:0];
                        acc_next = {acc_reg[30:0], 1'b0};
                    end
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'd32) begin
                        state_next = S_WB;
                        step_next  = 6'd33;
                    end
                end
            end
            S_POW: begin
                // Alternate multiply of result and squaring of base.
                if (r_reg == 32'd0) begin
                    state_next = S_WB;
                end else if (!sq_reg) begin
                    mul_a = res_reg;
                    mul_b = acc_reg;
                    if (r_reg[0]) begin
                        res_next = mul_p;
                    end
                    sq_next = 1'b1;
                end else begin
                    mul_a    = acc_reg;
                    mul_b    = acc_reg;
                    acc_next = mul_p;
                    r_next   = {1'b0, r_reg[31:1]};
                    sq_next  = 1'b0;
                end
            end
            S_WB: begin
                if (sym_reg == SymDiv && step_reg == 6'd33) begin
                    // Quotient sits in acc_reg; fix its sign.
                    ram_wdata = (l_reg[31] ^ r_reg[31]) ? (~acc_reg + 32'd1) : acc_reg;
                    step_next = '0;
                end
                ram_we     = 1'b1;
                ram_addr   = cnt_reg[PtrW-1:0] - PtrW'(2);
                cnt_next   = cnt_reg - CntW'(1);
                state_next = S_TOP;
            end
            S_TOP: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else begin
                    ram_addr   = cnt_reg[PtrW-1:0] - PtrW'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (err_reg != ST_OK) begin
                        m_data_next.value  = '0;
                        m_data_next.status = err_reg;
                    end else if (cnt_reg == '0) begin
                        m_data_next.value  = '0;
                        m_data_next.status = ST_UNDER;
                    end else begin
                        m_data_next.value  = ram_rdata;
                        m_data_next.status = ST_OK;
                    end
                    cnt_next   = '0;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end else begin
                    ram_addr = cnt_reg[PtrW-1:0] - PtrW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The stack count never exceeds the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(StackDepth))
        else $error("stack count beyond depth");

    // The output valid only rises when a result is loaded from the report state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside report state");

    // After a result is loaded the expression state is cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == S_OUT && state_reg == S_IDLE)
            |-> (cnt_reg == '0 && err_reg == ST_OK))
        else $error("stack not cleared after report");

endmodule
